/* rtl/msb_first_bit_packer_top_defines.svh */
// ------------------------------------------------------------------------
// msb_first_bit_packer_top_defines
// assertion macros shared by the bit packer rtl, clocked on i_clk and
// held off while i_rst_n is low
// ------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_TOP_DEFINES_SVH

// same-cycle implication
`define MBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mbp_pkg.sv */
// ------------------------------------------------------------------------
// mbp_pkg
// types, codes and constants of the msb-first bit packer
// ------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

    // store geometry
    localparam int STORE_BYTES = 1024;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int POS_W       = 14;
    localparam int POS_MAX     = 16383;
    localparam int CAP_W       = 11;
    localparam int CAP_RESET   = 1024;

    // item kinds
    typedef enum logic [2:0] {
        KIND_WRITE    = 3'd0,
        KIND_SEEK_ABS = 3'd1,
        KIND_SEEK_REL = 3'd2,
        KIND_SEEK_END = 3'd3,
        KIND_READ     = 3'd4,
        KIND_CLEAR    = 3'd5
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OP,
        ST_WR2
    } t_state;

    // low-bit masks indexed by count minus one
    localparam logic [7:0] LOW_MASKS [8] = '{
        8'h01, 8'h03, 8'h07, 8'h0f, 8'h1f, 8'h3f, 8'h7f, 8'hff
    };

endpackage

`default_nettype wire

/* rtl/msb_first_bit_packer_top.sv */
// ------------------------------------------------------------------------
// msb_first_bit_packer_top
// packs msb-first bit fields into a byte store (one write port, one read
// port) at a running bit position, with seek, byte read-back and clear items
// ------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result beat
// appears on the o_ result ports for a single cycle with o_strobe high and
// cannot be held off, so the receiver must take it then. Seeks, bad kinds,
// zero-count writes, out-of-range reads and writes dropped for capacity
// are answered from ST_IDLE; byte reads and writes within one byte pass
// through ST_OP; a write that spans two bytes passes through ST_OP and
// ST_WR2, one read-modify-write of the first byte plus one write of the
// second through the single memory write port. A clear item runs ST_CLEAR,
// which zeroes the store one byte a cycle; the same sweep runs after reset,
// keeping busy high before the first item. A new item may be taken in the
// cycle that shows the previous result. The capacity register may be written
// at any time the block is idle.
`default_nettype none

module msb_first_bit_packer_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [2:0]               i_kind,
    input  wire logic [7:0]               i_field_value,
    input  wire logic [3:0]               i_bit_count,
    input  wire logic signed [14:0]       i_seek_offset,
    input  wire logic [9:0]               i_read_address,
    input  wire logic                     i_cfg_we,
    input  wire logic [mbp_pkg::CAP_W-1:0] i_cfg_wdata,
    output logic                          o_strobe,
    output logic [3:0]                    o_bits_written,
    output logic [7:0]                    o_read_data,
    output logic                          o_status
);
    import mbp_pkg::*;

    `include "msb_first_bit_packer_top_defines.svh"

    // control registers
    t_state              r_state, n_state;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [CAP_W-1:0]    r_cap;
    logic [ADDR_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic                r_clr_ack, n_clr_ack;
    logic                r_strobe, n_strobe;

    // payload registers
    logic [3:0]          r_bits, n_bits;
    logic [7:0]          r_data, n_data;
    logic                r_status, n_status;
    logic                r_is_read;
    logic [7:0]          r_val;
    logic [3:0]          r_n;
    logic [2:0]          r_off;
    logic                r_strad;
    logic [ADDR_W-1:0]   r_idx;

    // byte store
    logic [7:0]          mem [STORE_BYTES];
    logic [7:0]          r_rdata;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    // accept-side decode
    logic                w_accept;
    logic [CAP_W-1:0]    w_cap;
    logic [3:0]          w_n;
    logic [2:0]          w_off;
    logic [3:0]          w_room;
    logic                w_strad;
    logic [CAP_W-1:0]    w_idx;
    logic [CAP_W:0]      w_last;
    logic                w_wr_ok;
    logic                w_rd_ok;
    logic signed [16:0]  w_seek;
    logic [POS_W-1:0]    w_seek_pos;

    // write datapath
    logic [7:0]          w_vm;
    logic [3:0]          w_room_r;
    logic [3:0]          w_rest;
    logic [15:0]         w_sh_first;
    logic [15:0]         w_sh_second;
    logic [15:0]         w_sh_plain;
    logic [7:0]          w_first;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // capacity in use, clamped to 1..STORE_BYTES
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (int'(r_cap) > STORE_BYTES) begin
            w_cap = CAP_W'(STORE_BYTES);
        end else begin
            w_cap = r_cap;
        end
    end

    // write geometry at the current position
    assign w_n     = (i_bit_count > 4'd8) ? 4'd8 : i_bit_count;
    assign w_off   = r_pos[2:0];
    assign w_room  = 4'd8 - {1'b0, w_off};
    assign w_strad = (w_n > w_room);
    assign w_idx   = r_pos[POS_W-1:3];
    assign w_last  = {1'b0, w_idx} + {{CAP_W{1'b0}}, w_strad};
    assign w_wr_ok = (w_last < {1'b0, w_cap});
    assign w_rd_ok = ({1'b0, i_read_address} < w_cap);

    // seek target before clamping
    always_comb begin
        case (i_kind)
            KIND_SEEK_REL: w_seek = $signed({3'b000, r_pos})
                                    + 17'(i_seek_offset);
            KIND_SEEK_END: w_seek = $signed({3'b000, w_cap, 3'b000})
                                    - 17'(i_seek_offset);
            default:       w_seek = 17'(i_seek_offset);
        endcase
    end

    // clamp to the position range
    always_comb begin
        if (w_seek < 0) begin
            w_seek_pos = '0;
        end else if (w_seek > 17'(POS_MAX)) begin
            w_seek_pos = POS_W'(POS_MAX);
        end else begin
            w_seek_pos = w_seek[POS_W-1:0];
        end
    end

    // merge of the field into the fetched byte
    assign w_vm        = r_val & LOW_MASKS[3'(r_n - 4'd1)];
    assign w_room_r    = 4'd8 - {1'b0, r_off};
    assign w_rest      = r_n - w_room_r;
    assign w_sh_first  = {8'h00, w_vm} >> w_rest;
    assign w_sh_second = {8'h00, w_vm} << (4'd8 - w_rest);
    assign w_sh_plain  = {8'h00, w_vm} << (4'd8 - {1'b0, r_off} - r_n);

    always_comb begin
        if (r_strad) begin
            w_first = r_rdata | w_sh_first[7:0];
        end else if (r_n == 4'd8 && r_off == 3'd0) begin
            w_first = r_val;
        end else begin
            w_first = r_rdata | w_sh_plain[7:0];
        end
    end

    // memory read address follows the item being taken
    assign mem_raddr = (i_kind == KIND_READ) ? ADDR_W'(i_read_address)
                                             : ADDR_W'(w_idx);

    // sequencer: next state, memory writes and result beat
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_clr_cnt = r_clr_cnt;
        n_clr_ack = r_clr_ack;
        n_strobe  = 1'b0;
        n_bits    = 4'd0;
        n_data    = 8'd0;
        n_status  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = w_first;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = 8'd0;
                n_clr_cnt = r_clr_cnt + ADDR_W'(1);
                if (r_clr_cnt == ADDR_W'(STORE_BYTES - 1)) begin
                    n_state   = ST_IDLE;
                    n_strobe  = r_clr_ack;
                    n_clr_ack = 1'b0;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_kind) inside
                        KIND_WRITE: begin
                            if (w_n == 4'd0) begin
                                n_strobe = 1'b1;
                            end else if (!w_wr_ok) begin
                                n_strobe = 1'b1;
                                n_status = 1'b1;
                            end else begin
                                n_state = ST_OP;
                                n_pos   = r_pos + POS_W'(w_n);
                            end
                        end
                        KIND_SEEK_ABS, KIND_SEEK_REL, KIND_SEEK_END: begin
                            n_pos    = w_seek_pos;
                            n_strobe = 1'b1;
                        end
                        KIND_READ: begin
                            if (w_rd_ok) begin
                                n_state = ST_OP;
                            end else begin
                                n_strobe = 1'b1;
                                n_status = 1'b1;
                            end
                        end
                        KIND_CLEAR: begin
                            n_state   = ST_CLEAR;
                            n_clr_cnt = '0;
                            n_clr_ack = 1'b1;
                            n_pos     = '0;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_OP: begin
                if (r_is_read) begin
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                    n_data   = r_rdata;
                end else begin
                    mem_we = 1'b1;
                    if (r_strad) begin
                        n_state = ST_WR2;
                    end else begin
                        n_state  = ST_IDLE;
                        n_strobe = 1'b1;
                        n_bits   = r_n;
                    end
                end
            end
            ST_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx + ADDR_W'(1);
                mem_wdata = w_sh_second[7:0];
                n_state   = ST_IDLE;
                n_strobe  = 1'b1;
                n_bits    = r_n;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state, reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_pos     <= '0;
            r_cap     <= CAP_W'(CAP_RESET);
            r_clr_cnt <= '0;
            r_clr_ack <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_clr_cnt <= n_clr_cnt;
            r_clr_ack <= n_clr_ack;
            r_strobe  <= n_strobe;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // item latch and result beat
    always_ff @(posedge i_clk) begin
        r_bits   <= n_bits;
        r_data   <= n_data;
        r_status <= n_status;
        if (w_accept) begin
            r_is_read <= (i_kind == KIND_READ);
            r_val     <= i_field_value;
            r_n       <= w_n;
            r_off     <= w_off;
            r_strad   <= w_strad;
            r_idx     <= ADDR_W'(w_idx);
        end
    end

    // byte store, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign o_strobe       = r_strobe;
    assign o_bits_written = r_bits;
    assign o_read_data    = r_data;
    assign o_status       = r_status;

    // checks
    `MBP_ASSERT_IMP(a_wr2_follows_op, r_state == ST_WR2, $past(r_state) == ST_OP, "second byte write without first")
    `MBP_ASSERT_IMP(a_wr2_no_beat, r_state == ST_WR2, !o_strobe, "result beat during second byte write")
    `MBP_ASSERT_NXT(a_clear_pos, w_accept && i_kind == KIND_CLEAR, r_pos == '0 && r_state == ST_CLEAR, "clear did not reset position")
    `MBP_ASSERT_IMP(a_no_write_idle, r_state == ST_IDLE, !mem_we, "store written while idle")

endmodule

`default_nettype wire

/* tb/tb.sv */
// ------------------------------------------------------------------------
// tb
// self-checking bench for the msb-first bit packer: a driver feeds write,
// seek, read, clear and bad-kind items from a queue, a predictor shadows
// the bit position and the byte store, and a monitor compares every
// result beat field by field against the oldest prediction
// ------------------------------------------------------------------------
module tb;

    import mbp_pkg::*;

    // kinds outside the defined set
    localparam logic [2:0] KIND_RESERVED_6 = 3'd6;
    localparam logic [2:0] KIND_RESERVED_7 = 3'd7;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 140;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         value;
        logic [3:0]         count;
        logic signed [14:0] offset;
        logic [9:0]         addr;
    } t_packer_cmd;

    typedef struct packed {
        logic [3:0] bits_written;
        logic [7:0] read_data;
        logic       status;
    } t_packer_beat;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic                 busy;
    logic [2:0]           i_kind         = '0;
    logic [7:0]           i_field_value  = '0;
    logic [3:0]           i_bit_count    = '0;
    logic signed [14:0]   i_seek_offset  = '0;
    logic [9:0]           i_read_address = '0;
    logic                 i_cfg_we       = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata    = '0;
    logic                 o_strobe;
    logic [3:0]           o_bits_written;
    logic [7:0]           o_read_data;
    logic                 o_status;

    // shadow of the block state
    logic [7:0]   store_image [STORE_BYTES];
    int           cursor_bits;
    int           cap_bytes;

    t_packer_cmd  pending_cmds [$];
    t_packer_beat expected_beats [$];
    t_packer_cmd  active_cmd;
    t_packer_cmd  next_cmd;
    int           gap_left;
    int           burst_left;
    int           stall_cycles;
    int           fail_count;

    msb_first_bit_packer_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_field_value  (i_field_value),
        .i_bit_count    (i_bit_count),
        .i_seek_offset  (i_seek_offset),
        .i_read_address (i_read_address),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_bits_written (o_bits_written),
        .o_read_data    (o_read_data),
        .o_status       (o_status)
    );

    always #10 i_clk = ~i_clk;

    // seek results saturate to the 14-bit position range
    function automatic int clamp_cursor(input int target);
        if (target < 0)
            return 0;
        if (target > POS_MAX)
            return POS_MAX;
        return target;
    endfunction

    // applies one item to the shadow state and returns its result beat
    function automatic t_packer_beat pack_step(input t_packer_cmd c);
        t_packer_beat r;
        int           n, idx, off, room, rest, last;
        logic [7:0]   field;
        r = '0;
        case (c.kind)
            KIND_WRITE: begin
                n = (c.count > 4'd8) ? 8 : int'(c.count);
                if (n != 0) begin
                    idx  = cursor_bits >> 3;
                    off  = cursor_bits & 7;
                    room = 8 - off;
                    last = (room < n) ? idx + 1 : idx;
                    if (last >= cap_bytes) begin
                        r.status = 1'b1;
                    end else begin
                        field = c.value & (8'hff >> (8 - n));
                        if (room < n) begin
                            // leading part ors in, trailing part overwrites
                            rest = n - room;
                            store_image[idx]     = store_image[idx] | (field >> rest);
                            store_image[idx + 1] = field << (8 - rest);
                        end else if (n == 8 && off == 0) begin
                            store_image[idx] = c.value;
                        end else begin
                            store_image[idx] = store_image[idx] | (field << (8 - off - n));
                        end
                        cursor_bits    = (cursor_bits + n) & 16'h3fff;
                        r.bits_written = 4'(n);
                    end
                end
            end
            KIND_SEEK_ABS: cursor_bits = clamp_cursor($signed(c.offset));
            KIND_SEEK_REL: cursor_bits = clamp_cursor(cursor_bits + $signed(c.offset));
            KIND_SEEK_END: cursor_bits = clamp_cursor(cap_bytes * 8 - $signed(c.offset));
            KIND_READ: begin
                if (int'(c.addr) < cap_bytes)
                    r.read_data = store_image[c.addr];
                else
                    r.status = 1'b1;
            end
            KIND_CLEAR: begin
                foreach (store_image[i])
                    store_image[i] = '0;
                cursor_bits = 0;
            end
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    function automatic t_packer_cmd rand_cmd(input logic [2:0] kind);
        t_packer_cmd c;
        c.kind   = kind;
        c.value  = 8'($urandom);
        c.count  = 4'($urandom);
        c.offset = 15'($urandom);
        c.addr   = 10'($urandom);
        return c;
    endfunction

    task automatic queue_fields(input logic [2:0] kind, input logic [7:0] value,
                                input logic [3:0] count, input logic [14:0] offset,
                                input logic [9:0] addr);
        pending_cmds.push_back('{kind, value, count, offset, addr});
    endtask

    // block until every item is taken, every beat is back and the block is free
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_cmds.size() != 0 || expected_beats.size() != 0 || start || busy);
        @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        cap_bytes = (value == 0) ? 1 : (value > STORE_BYTES) ? STORE_BYTES : int'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // runs of position, field writes and read-back, with some noise between
    task automatic queue_random_phase(input int target_items);
        t_packer_cmd c;
        int          queued, hint, span, roll, k;
        queued = 0;
        hint   = cursor_bits;
        span   = cap_bytes * 8;
        while (queued < target_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                pending_cmds.push_back(rand_cmd(KIND_CLEAR));
                hint   = 0;
                queued = queued + 1;
            end else if (roll < 15) begin
                pending_cmds.push_back(rand_cmd(3'($urandom_range(0, 7))));
                queued = queued + 1;
            end else begin
                // place the position
                roll = $urandom_range(0, 7);
                if (roll < 5) begin
                    c        = rand_cmd(KIND_SEEK_ABS);
                    hint     = $urandom_range(0, span - 1);
                    c.offset = 15'(hint);
                end else if (roll < 7) begin
                    c        = rand_cmd(KIND_SEEK_REL);
                    k        = $urandom_range(0, 32) - 16;
                    c.offset = 15'(k);
                    hint     = clamp_cursor(hint + k);
                end else begin
                    c        = rand_cmd(KIND_SEEK_END);
                    k        = $urandom_range(0, 24);
                    c.offset = 15'(k);
                    hint     = clamp_cursor(span - k);
                end
                pending_cmds.push_back(c);
                queued = queued + 1;
                // burst of fields
                repeat ($urandom_range(1, 10)) begin
                    c = rand_cmd(KIND_WRITE);
                    if ($urandom_range(0, 4) != 0)
                        c.count = 4'($urandom_range(1, 8));
                    k = (c.count > 4'd8) ? 8 : int'(c.count);
                    if (hint + k <= span)
                        hint = hint + k;
                    pending_cmds.push_back(c);
                    queued = queued + 1;
                end
                // read back the bytes just touched
                repeat ($urandom_range(1, 3)) begin
                    c      = rand_cmd(KIND_READ);
                    k      = (hint >> 3) - $urandom_range(0, 2);
                    c.addr = (k < 0) ? 10'd0 : 10'(k);
                    pending_cmds.push_back(c);
                    queued = queued + 1;
                end
            end
        end
    endtask

    // driver: one beat per item, random gaps with occasional back-to-back bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (start && !busy)
                expected_beats.push_back(pack_step(active_cmd));
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_cmd = pending_cmds.pop_front();
                    active_cmd     <= next_cmd;
                    i_kind         <= next_cmd.kind;
                    i_field_value  <= next_cmd.value;
                    i_bit_count    <= next_cmd.count;
                    i_seek_offset  <= next_cmd.offset;
                    i_read_address <= next_cmd.addr;
                    start          <= 1'b1;
                    if (burst_left != 0) begin
                        burst_left <= burst_left - 1;
                        gap_left   <= 0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        burst_left <= $urandom_range(8, 40);
                        gap_left   <= 0;
                    end else begin
                        gap_left <= $urandom_range(0, 15);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed beat against the oldest prediction
    always @(posedge i_clk) begin
        t_packer_beat want;
        if (i_rst_n && o_strobe) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with no item outstanding");
                fail_count = fail_count + 1;
            end else begin
                want = expected_beats.pop_front();
                if (o_bits_written !== want.bits_written) begin
                    $error("bits_written: expected %0d, got %0d",
                           want.bits_written, o_bits_written);
                    fail_count = fail_count + 1;
                end
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected 0x%02h, got 0x%02h",
                           want.read_data, o_read_data);
                    fail_count = fail_count + 1;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [CAP_W-1:0] cap_plan [10];
        foreach (store_image[i])
            store_image[i] = '0;
        cursor_bits  = 0;
        cap_bytes    = CAP_RESET;
        fail_count   = 0;
        stall_cycles = 0;
        cap_plan = '{11'd1, 11'd2, 11'd1024, 11'd16, 11'd0, 11'd2047, 11'd64,
                     11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)), 11'd3};

        // directed: zero count, aligned byte, straddles, saturation, bounds
        queue_fields(KIND_WRITE,    8'hff, 4'd0,  15'h0000, 10'd0);
        queue_fields(KIND_WRITE,    8'hff, 4'd8,  15'h0000, 10'd0);
        queue_fields(KIND_WRITE,    8'h01, 4'd1,  15'h0000, 10'd0);
        queue_fields(KIND_WRITE,    8'h5a, 4'd15, 15'h7fff, 10'h3ff);
        queue_fields(KIND_WRITE,    8'hff, 4'd3,  15'h0000, 10'd0);
        queue_fields(KIND_READ,     8'h00, 4'd0,  15'h0000, 10'd0);
        queue_fields(KIND_READ,     8'h00, 4'd0,  15'h0000, 10'd1);
        queue_fields(KIND_READ,     8'h00, 4'd0,  15'h0000, 10'd2);
        queue_fields(KIND_SEEK_ABS, 8'h00, 4'd0,  15'h4000, 10'd0);
        queue_fields(KIND_WRITE,    8'h03, 4'd4,  15'h0000, 10'd0);
        queue_fields(KIND_SEEK_ABS, 8'h00, 4'd0,  15'h3fff, 10'd0);
        queue_fields(KIND_WRITE,    8'h01, 4'd1,  15'h0000, 10'd0);
        queue_fields(KIND_SEEK_REL, 8'h00, 4'd0,  15'h4000, 10'd0);
        queue_fields(KIND_SEEK_REL, 8'h00, 4'd0,  15'h3fff, 10'd0);
        queue_fields(KIND_SEEK_END, 8'h00, 4'd0,  15'h0000, 10'd0);
        queue_fields(KIND_WRITE,    8'h03, 4'd2,  15'h0000, 10'd0);
        queue_fields(KIND_SEEK_END, 8'h00, 4'd0,  15'h0009, 10'd0);
        queue_fields(KIND_WRITE,    8'h03, 4'd2,  15'h0000, 10'd0);
        queue_fields(KIND_READ,     8'h00, 4'd0,  15'h0000, 10'h3ff);
        queue_fields(KIND_SEEK_END, 8'h00, 4'd0,  15'h4000, 10'd0);
        queue_fields(KIND_SEEK_END, 8'h00, 4'd0,  15'h3fff, 10'd0);
        queue_fields(KIND_RESERVED_6, 8'h00, 4'd0, 15'h0000, 10'd0);
        queue_fields(KIND_RESERVED_7, 8'hff, 4'd15, 15'h7fff, 10'h3ff);
        queue_fields(KIND_CLEAR,    8'h00, 4'd0,  15'h0000, 10'd0);
        queue_fields(KIND_READ,     8'h00, 4'd0,  15'h0000, 10'd1);

        // synchronous reset, then the block sweeps its store
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // each capacity change waits for the pipeline to drain
        foreach (cap_plan[p]) begin
            set_capacity(cap_plan[p]);
            queue_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* msb_first_bit_packer_top.f */
+incdir+rtl
rtl/mbp_pkg.sv
rtl/msb_first_bit_packer_top.sv
tb/tb.sv
